// ===== hdl/wcs_pkg.sv =====
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared constants, codes and beat types for the wall column span pipeline.
// ----------------------------------------------------------------------------
package wcs_pkg;

   // Screen geometry.
   localparam int SCREEN_WIDTH  = 256;
   localparam int SCREEN_HEIGHT = 256;
   localparam int X_MIN         = 1;
   localparam int X_MAX         = SCREEN_WIDTH - 1;
   localparam int Y_MIN         = 1;
   localparam int Y_MAX         = SCREEN_HEIGHT - 1;

   // Field widths.
   localparam int COORD_W = 16;
   localparam int COL_W   = 8;
   localparam int FUNC_W  = 3;
   localparam int COLOR_W = 24;
   localparam int EDGE_W  = 8;
   localparam int KIND_W  = 2;

   // Divider shape: 2*dx fits 17 bits, the quotient needs 8 bits before
   // saturation, and two quotient bits are resolved per pipeline stage.
   localparam int DIV_W           = 17;
   localparam int QUO_W           = 8;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

   // Per-column edge store.
   localparam int STORE_DEPTH = 256;

   // Surface mode codes.
   localparam logic [FUNC_W-1:0] FUNC_WALL     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REC_LOW  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REC_HIGH = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_FLOOR    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CEIL     = 3'd4;

   // Fill kind codes.
   localparam logic [KIND_W-1:0] FILL_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] FILL_FLOOR = 2'd1;
   localparam logic [KIND_W-1:0] FILL_CEIL  = 2'd2;

   // Sideband that travels with every beat down the pipeline.
   typedef struct packed {
      logic               in_range;
      logic [COL_W-1:0]   col;
      logic [FUNC_W-1:0]  func;
      logic [COLOR_W-1:0] wall_color;
      logic [COLOR_W-1:0] fill_color;
   } item_info_type;

   // Division state of one edge. The low quotient bits shift in at the
   // bottom of bits while the remaining dividend bits shift out at the top.
   typedef struct packed {
      logic              nonpos;
      logic              sat;
      logic [DIV_W-1:0]  part;
      logic [QUO_W-1:0]  bits;
   } div_edge_type;

endpackage

// ===== hdl/wcs_setup.sv =====
// ----------------------------------------------------------------------------
// wcs_setup
// Front of the pipeline: range test and differences, the four products, and
// the numerator sum with its sign and saturation tests. Three stages.
// ----------------------------------------------------------------------------
module wcs_setup
   import wcs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  logic signed [COORD_W-1:0] start_x,
   input  logic signed [COORD_W-1:0] end_x,
   input  logic signed [COORD_W-1:0] bottom_start,
   input  logic signed [COORD_W-1:0] bottom_end,
   input  logic signed [COORD_W-1:0] top_start,
   input  logic signed [COORD_W-1:0] top_end,
   input  logic [COL_W-1:0]          column,
   input  logic [FUNC_W-1:0]         func,
   input  logic [COLOR_W-1:0]        wall_color,
   input  logic [COLOR_W-1:0]        fill_color,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output item_info_type             dn_info,
   output logic [DIV_W-1:0]          dn_div,
   output div_edge_type              dn_lo,
   output div_edge_type              dn_hi
);

   localparam logic signed [DIV_W-1:0] XC_LO = DIV_W'(X_MIN);
   localparam logic signed [DIV_W-1:0] XC_HI = DIV_W'(X_MAX);

   // Clamp a wall end position to the drawable column range.
   function automatic logic signed [DIV_W-1:0] clamp_x(input logic signed [COORD_W-1:0] v);
      logic signed [DIV_W-1:0] w;
      begin
         w = {v[COORD_W-1], v};
         if (w < XC_LO) begin
            clamp_x = XC_LO;
         end else if (w > XC_HI) begin
            clamp_x = XC_HI;
         end else begin
            clamp_x = w;
         end
      end
   endfunction

   // Stage enables: a stage loads when it is empty or its beat moves on.
   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;

   assign en3      = !v3_ff || dn_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign up_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= up_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Stage 1: clamped range test, wall width, column offset and edge slopes.
   logic signed [DIV_W-1:0] xs_w, xe_w, col_w, dx_raw, dx_w, lo_x, hi_x, t_w;
   logic signed [DIV_W:0]   t2p1_in;
   logic signed [DIV_W-1:0] dy_lo_in, dy_hi_in;
   item_info_type           info1_in;

   assign xs_w    = {start_x[COORD_W-1], start_x};
   assign xe_w    = {end_x[COORD_W-1], end_x};
   assign col_w   = {{(DIV_W-COL_W){1'b0}}, column};
   assign dx_raw  = xe_w - xs_w;
   assign dx_w    = (dx_raw == '0) ? DIV_W'(1) : dx_raw;
   assign lo_x    = clamp_x(start_x);
   assign hi_x    = clamp_x(end_x);
   assign t_w     = col_w - xs_w;
   assign t2p1_in = {t_w, 1'b1};
   assign dy_lo_in = {bottom_end[COORD_W-1], bottom_end} - {bottom_start[COORD_W-1], bottom_start};
   assign dy_hi_in = {top_end[COORD_W-1], top_end} - {top_start[COORD_W-1], top_start};

   always_comb begin
      info1_in.in_range   = (col_w >= lo_x) && (col_w < hi_x);
      info1_in.col        = column;
      info1_in.func       = func;
      info1_in.wall_color = wall_color;
      info1_in.fill_color = fill_color;
   end

   item_info_type           info1_ff;
   logic signed [DIV_W-1:0] dx1_ff, dy_lo1_ff, dy_hi1_ff;
   logic signed [DIV_W:0]   t2p1_ff;
   logic signed [COORD_W-1:0] b_lo1_ff, b_hi1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         info1_ff  <= info1_in;
         dx1_ff    <= dx_w;
         t2p1_ff   <= t2p1_in;
         dy_lo1_ff <= dy_lo_in;
         dy_hi1_ff <= dy_hi_in;
         b_lo1_ff  <= bottom_start;
         b_hi1_ff  <= top_start;
      end
   end

   // Stage 2: slope times (2t+1) and start edge times dx, for both edges.
   localparam int PDY_W = 2 * DIV_W + 1;
   localparam int PB_W  = COORD_W + DIV_W;
   localparam int NUM_W = PDY_W + 1;

   logic signed [PDY_W-1:0] pdy_lo_in, pdy_hi_in;
   logic signed [PB_W-1:0]  pb_lo_in, pb_hi_in;

   assign pdy_lo_in = dy_lo1_ff * t2p1_ff;
   assign pdy_hi_in = dy_hi1_ff * t2p1_ff;
   assign pb_lo_in  = b_lo1_ff * dx1_ff;
   assign pb_hi_in  = b_hi1_ff * dx1_ff;

   item_info_type           info2_ff;
   logic [DIV_W-1:0]        dx2_ff;
   logic signed [PDY_W-1:0] pdy_lo_ff, pdy_hi_ff;
   logic signed [PB_W-1:0]  pb_lo_ff, pb_hi_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         info2_ff  <= info1_ff;
         dx2_ff    <= dx1_ff;
         pdy_lo_ff <= pdy_lo_in;
         pdy_hi_ff <= pdy_hi_in;
         pb_lo_ff  <= pb_lo_in;
         pb_hi_ff  <= pb_hi_in;
      end
   end

   // Stage 3: numerator, sign test and quotient saturation test.
   // The divisor is 2*dx; dx is positive whenever the column is in range.
   logic [DIV_W-1:0] div_in;

   assign div_in = {dx2_ff[DIV_W-2:0], 1'b0};

   function automatic div_edge_type start_edge(input logic signed [PDY_W-1:0] pdy,
                                               input logic signed [PB_W-1:0]  pb,
                                               input logic [DIV_W-1:0]        d);
      logic signed [NUM_W-1:0]  num;
      logic [NUM_W-QUO_W-1:0]   nh;
      div_edge_type             e;
      begin
         num      = {pdy[PDY_W-1], pdy} + {{(NUM_W-PB_W-1){pb[PB_W-1]}}, pb, 1'b0};
         nh       = num[NUM_W-1:QUO_W];
         e.nonpos = num[NUM_W-1] || (num == '0);
         e.sat    = nh >= {{(NUM_W-QUO_W-DIV_W){1'b0}}, d};
         e.part   = nh[DIV_W-1:0];
         e.bits   = num[QUO_W-1:0];
         start_edge = e;
      end
   endfunction

   item_info_type    info3_ff;
   logic [DIV_W-1:0] div3_ff;
   div_edge_type     lo3_ff, hi3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         info3_ff <= info2_ff;
         div3_ff  <= div_in;
         lo3_ff   <= start_edge(pdy_lo_ff, pb_lo_ff, div_in);
         hi3_ff   <= start_edge(pdy_hi_ff, pb_hi_ff, div_in);
      end
   end

   assign dn_valid = v3_ff;
   assign dn_info  = info3_ff;
   assign dn_div   = div3_ff;
   assign dn_lo    = lo3_ff;
   assign dn_hi    = hi3_ff;

endmodule

// ===== hdl/wcs_div_stage.sv =====
// ----------------------------------------------------------------------------
// wcs_div_stage
// One stage of the restoring divider: resolves two quotient bits of both
// edges against the shared divisor, then registers the beat.
// ----------------------------------------------------------------------------
module wcs_div_stage
   import wcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   output logic             up_ready,
   input  item_info_type    up_info,
   input  logic [DIV_W-1:0] up_div,
   input  div_edge_type     up_lo,
   input  div_edge_type     up_hi,
   output logic             dn_valid,
   input  logic             dn_ready,
   output item_info_type    dn_info,
   output logic [DIV_W-1:0] dn_div,
   output div_edge_type     dn_lo,
   output div_edge_type     dn_hi
);

   // One long-division step: bring down the next dividend bit, subtract the
   // divisor when it fits, and shift the quotient bit in at the bottom.
   function automatic div_edge_type div_step(input div_edge_type e, input logic [DIV_W-1:0] d);
      logic [DIV_W:0] trial;
      logic [DIV_W:0] diff;
      logic           qbit;
      div_edge_type   r;
      begin
         trial = {e.part, e.bits[QUO_W-1]};
         diff  = trial - {1'b0, d};
         qbit  = trial >= {1'b0, d};
         r        = e;
         r.part   = qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         r.bits   = {e.bits[QUO_W-2:0], qbit};
         div_step = r;
      end
   endfunction

   div_edge_type lo_in, hi_in;

   always_comb begin
      lo_in = up_lo;
      hi_in = up_hi;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         lo_in = div_step(lo_in, up_div);
         hi_in = div_step(hi_in, up_div);
      end
   end

   // Stage register with its valid bit.
   logic             en;
   logic             v_ff;
   item_info_type    info_ff;
   logic [DIV_W-1:0] div_ff;
   div_edge_type     lo_ff, hi_ff;

   assign en       = !v_ff || dn_ready;
   assign up_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         info_ff <= up_info;
         div_ff  <= up_div;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
      end
   end

   assign dn_valid = v_ff;
   assign dn_info  = info_ff;
   assign dn_div   = div_ff;
   assign dn_lo    = lo_ff;
   assign dn_hi    = hi_ff;

endmodule

// ===== hdl/wcs_span.sv =====
// ----------------------------------------------------------------------------
// wcs_span
// Back of the pipeline: clamps both edges, keeps the per-column edge store,
// and builds the wall and fill spans in the output register.
// ----------------------------------------------------------------------------
module wcs_span
   import wcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  item_info_type      up_info,
   input  div_edge_type       up_lo,
   input  div_edge_type       up_hi,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_column_drawn,
   output logic [EDGE_W-1:0]  rsp_span_low,
   output logic [EDGE_W-1:0]  rsp_span_high,
   output logic [COLOR_W-1:0] rsp_span_color,
   output logic [KIND_W-1:0]  rsp_fill_kind,
   output logic [EDGE_W-1:0]  rsp_fill_from,
   output logic [EDGE_W-1:0]  rsp_fill_to,
   output logic [COLOR_W-1:0] rsp_fill_color_out
);

   localparam logic [EDGE_W-1:0] Y_LO = EDGE_W'(Y_MIN);
   localparam logic [EDGE_W-1:0] Y_HI = EDGE_W'(Y_MAX);

   // Clamp a finished quotient to the drawable row range.
   function automatic logic [EDGE_W-1:0] clamp_edge(input div_edge_type e);
      logic [EDGE_W-1:0] q;
      begin
         q = e.bits[EDGE_W-1:0];
         if (e.nonpos) begin
            clamp_edge = Y_LO;
         end else if (e.sat) begin
            clamp_edge = Y_HI;
         end else if (q < Y_LO) begin
            clamp_edge = Y_LO;
         end else if (q > Y_HI) begin
            clamp_edge = Y_HI;
         end else begin
            clamp_edge = q;
         end
      end
   endfunction

   // Stage enables for the edge stage and the output register.
   logic en_r, en_o;
   logic r_valid_ff, o_valid_ff;

   assign en_o     = !o_valid_ff || rsp_ready;
   assign en_r     = !r_valid_ff || en_o;
   assign up_ready = en_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (en_r) r_valid_ff <= up_valid;
         if (en_o) o_valid_ff <= r_valid_ff;
      end
   end

   // Edge stage: clamped edges plus the stored edge of the beat's column.
   item_info_type     r_info_ff;
   logic [EDGE_W-1:0] r_y_lo_ff, r_y_hi_ff, r_stored_ff;

   always_ff @(posedge clock) begin
      if (en_r) begin
         r_info_ff <= up_info;
         r_y_lo_ff <= clamp_edge(up_lo);
         r_y_hi_ff <= clamp_edge(up_hi);
      end
   end

   // Record modes write the store as their beat leaves the edge stage.
   logic              wr_en;
   logic [COL_W-1:0]  wr_addr;
   logic [EDGE_W-1:0] wr_data;

   assign wr_en   = en_o && r_valid_ff && r_info_ff.in_range &&
                    ((r_info_ff.func == FUNC_REC_LOW) || (r_info_ff.func == FUNC_REC_HIGH));
   assign wr_addr = r_info_ff.col;
   assign wr_data = (r_info_ff.func == FUNC_REC_LOW) ? r_y_lo_ff : r_y_hi_ff;

   logic [EDGE_W-1:0] edge_mem_ff [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] entry_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         edge_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Valid bits stand in for clearing the store: an unwritten entry reads zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
      end else if (wr_en) begin
         entry_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read as a beat enters the edge stage; a write to the same
   // column on that edge is forwarded.
   always_ff @(posedge clock) begin
      if (en_r) begin
         if (wr_en && (wr_addr == up_info.col)) begin
            r_stored_ff <= wr_data;
         end else if (entry_vld_ff[up_info.col]) begin
            r_stored_ff <= edge_mem_ff[up_info.col];
         end else begin
            r_stored_ff <= '0;
         end
      end
   end

   // Output composition: out-of-range and record beats give an all-zero result.
   logic               drawn_in;
   logic [EDGE_W-1:0]  span_low_in, span_high_in, fill_from_in, fill_to_in;
   logic [COLOR_W-1:0] span_color_in, fill_color_in;
   logic [KIND_W-1:0]  fill_kind_in;

   always_comb begin
      drawn_in      = r_info_ff.in_range && (r_info_ff.func != FUNC_REC_LOW) &&
                      (r_info_ff.func != FUNC_REC_HIGH);
      span_low_in   = '0;
      span_high_in  = '0;
      span_color_in = '0;
      fill_kind_in  = FILL_NONE;
      fill_from_in  = '0;
      fill_to_in    = '0;
      fill_color_in = '0;
      if (drawn_in) begin
         span_low_in   = r_y_lo_ff;
         span_high_in  = r_y_hi_ff;
         span_color_in = r_info_ff.wall_color;
         unique case (r_info_ff.func)
            FUNC_FLOOR: begin
               fill_kind_in  = FILL_FLOOR;
               fill_from_in  = r_stored_ff;
               fill_to_in    = r_y_lo_ff;
               fill_color_in = r_info_ff.fill_color;
            end
            FUNC_CEIL: begin
               fill_kind_in  = FILL_CEIL;
               fill_from_in  = r_y_hi_ff;
               fill_to_in    = r_stored_ff;
               fill_color_in = r_info_ff.fill_color;
            end
            default: begin
               fill_kind_in = FILL_NONE;
            end
         endcase
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (en_o) begin
         rsp_column_drawn   <= drawn_in;
         rsp_span_low       <= span_low_in;
         rsp_span_high      <= span_high_in;
         rsp_span_color     <= span_color_in;
         rsp_fill_kind      <= fill_kind_in;
         rsp_fill_from      <= fill_from_in;
         rsp_fill_to        <= fill_to_in;
         rsp_fill_color_out <= fill_color_in;
      end
   end

   assign rsp_valid = o_valid_ff;

endmodule

// ===== hdl/wall_column_span.sv =====
// ----------------------------------------------------------------------------
// wall_column_span
// Nine register stages lie between a request beat and its result: setup,
// products, numerator, four divider stages, edge and store stage, and the
// output register.
// Throughput: one beat per cycle; each stage stalls only when full and blocked.
// Reset (synchronous, active high) empties the pipeline and marks every edge
// store entry unwritten, so the store reads as zero with no clearing pass.
// ----------------------------------------------------------------------------
module wall_column_span
   import wcs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_bottom_start,
   input  logic signed [COORD_W-1:0] req_bottom_end,
   input  logic signed [COORD_W-1:0] req_top_start,
   input  logic signed [COORD_W-1:0] req_top_end,
   input  logic [COL_W-1:0]          req_column,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [COLOR_W-1:0]        req_wall_color,
   input  logic [COLOR_W-1:0]        req_fill_color,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_column_drawn,
   output logic [EDGE_W-1:0]         rsp_span_low,
   output logic [EDGE_W-1:0]         rsp_span_high,
   output logic [COLOR_W-1:0]        rsp_span_color,
   output logic [KIND_W-1:0]         rsp_fill_kind,
   output logic [EDGE_W-1:0]         rsp_fill_from,
   output logic [EDGE_W-1:0]         rsp_fill_to,
   output logic [COLOR_W-1:0]        rsp_fill_color_out
);

   // Beats between the setup front, the divider stages and the span back end.
   logic             pipe_valid [DIV_STAGES+1];
   logic             pipe_ready [DIV_STAGES+1];
   item_info_type    pipe_info  [DIV_STAGES+1];
   logic [DIV_W-1:0] pipe_div   [DIV_STAGES+1];
   div_edge_type     pipe_lo    [DIV_STAGES+1];
   div_edge_type     pipe_hi    [DIV_STAGES+1];

   wcs_setup u_setup (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_valid),
      .up_ready     (req_ready),
      .start_x      (req_start_x),
      .end_x        (req_end_x),
      .bottom_start (req_bottom_start),
      .bottom_end   (req_bottom_end),
      .top_start    (req_top_start),
      .top_end      (req_top_end),
      .column       (req_column),
      .func         (req_func),
      .wall_color   (req_wall_color),
      .fill_color   (req_fill_color),
      .dn_valid     (pipe_valid[0]),
      .dn_ready     (pipe_ready[0]),
      .dn_info      (pipe_info[0]),
      .dn_div       (pipe_div[0]),
      .dn_lo        (pipe_lo[0]),
      .dn_hi        (pipe_hi[0])
   );

   // Divider: two quotient bits per stage.
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      wcs_div_stage u_div (
         .clock    (clock),
         .reset    (reset),
         .up_valid (pipe_valid[g]),
         .up_ready (pipe_ready[g]),
         .up_info  (pipe_info[g]),
         .up_div   (pipe_div[g]),
         .up_lo    (pipe_lo[g]),
         .up_hi    (pipe_hi[g]),
         .dn_valid (pipe_valid[g+1]),
         .dn_ready (pipe_ready[g+1]),
         .dn_info  (pipe_info[g+1]),
         .dn_div   (pipe_div[g+1]),
         .dn_lo    (pipe_lo[g+1]),
         .dn_hi    (pipe_hi[g+1])
      );
   end

   wcs_span u_span (
      .clock              (clock),
      .reset              (reset),
      .up_valid           (pipe_valid[DIV_STAGES]),
      .up_ready           (pipe_ready[DIV_STAGES]),
      .up_info            (pipe_info[DIV_STAGES]),
      .up_lo              (pipe_lo[DIV_STAGES]),
      .up_hi              (pipe_hi[DIV_STAGES]),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_column_drawn   (rsp_column_drawn),
      .rsp_span_low       (rsp_span_low),
      .rsp_span_high      (rsp_span_high),
      .rsp_span_color     (rsp_span_color),
      .rsp_fill_kind      (rsp_fill_kind),
      .rsp_fill_from      (rsp_fill_from),
      .rsp_fill_to        (rsp_fill_to),
      .rsp_fill_color_out (rsp_fill_color_out)
   );

endmodule

// ===== sim/wall_column_span_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wall_column_span_tb
// Self-checking bench for the wall column span block. A queue of column beats,
// directed first and then random, feeds a clocked driver. Every accepted beat
// runs through an in-bench predictor that keeps its own copy of the
// per-column edge store, and a clocked monitor compares each result beat,
// field by field, with the oldest prediction. Four phases vary how often the
// sender idles and the receiver stalls.
// ----------------------------------------------------------------------------
module wall_column_span_tb;
   import wcs_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PER_PHASE = 212;

   // One request beat as the bench holds it.
   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] bottom_start;
      logic [COORD_W-1:0] bottom_end;
      logic [COORD_W-1:0] top_start;
      logic [COORD_W-1:0] top_end;
      logic [COL_W-1:0]   column;
      logic [FUNC_W-1:0]  func;
      logic [COLOR_W-1:0] wall_color;
      logic [COLOR_W-1:0] fill_color;
   } column_beat_type;

   // One result beat as the bench predicts it.
   typedef struct packed {
      logic               column_drawn;
      logic [EDGE_W-1:0]  span_low;
      logic [EDGE_W-1:0]  span_high;
      logic [COLOR_W-1:0] span_color;
      logic [KIND_W-1:0]  fill_kind;
      logic [EDGE_W-1:0]  fill_from;
      logic [EDGE_W-1:0]  fill_to;
      logic [COLOR_W-1:0] fill_color_out;
   } span_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_start_x = '0;
   logic signed [COORD_W-1:0] req_end_x = '0;
   logic signed [COORD_W-1:0] req_bottom_start = '0;
   logic signed [COORD_W-1:0] req_bottom_end = '0;
   logic signed [COORD_W-1:0] req_top_start = '0;
   logic signed [COORD_W-1:0] req_top_end = '0;
   logic [COL_W-1:0]          req_column = '0;
   logic [FUNC_W-1:0]         req_func = '0;
   logic [COLOR_W-1:0]        req_wall_color = '0;
   logic [COLOR_W-1:0]        req_fill_color = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_column_drawn;
   logic [EDGE_W-1:0]         rsp_span_low;
   logic [EDGE_W-1:0]         rsp_span_high;
   logic [COLOR_W-1:0]        rsp_span_color;
   logic [KIND_W-1:0]         rsp_fill_kind;
   logic [EDGE_W-1:0]         rsp_fill_from;
   logic [EDGE_W-1:0]         rsp_fill_to;
   logic [COLOR_W-1:0]        rsp_fill_color_out;

   // Pending request beats and predicted result beats.
   column_beat_type column_q[$];
   span_result_type span_due_q[$];
   column_beat_type bus_beat;
   span_result_type rsp_want;

   // The bench's own copy of the per-column edge store.
   logic [EDGE_W-1:0] edge_mem [STORE_DEPTH];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int results_seen = 0;
   int random_added = 0;
   int quiet_cycles = 0;

   wall_column_span u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_x        (req_start_x),
      .req_end_x          (req_end_x),
      .req_bottom_start   (req_bottom_start),
      .req_bottom_end     (req_bottom_end),
      .req_top_start      (req_top_start),
      .req_top_end        (req_top_end),
      .req_column         (req_column),
      .req_func           (req_func),
      .req_wall_color     (req_wall_color),
      .req_fill_color     (req_fill_color),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_column_drawn   (rsp_column_drawn),
      .rsp_span_low       (rsp_span_low),
      .rsp_span_high      (rsp_span_high),
      .rsp_span_color     (rsp_span_color),
      .rsp_fill_kind      (rsp_fill_kind),
      .rsp_fill_from      (rsp_fill_from),
      .rsp_fill_to        (rsp_fill_to),
      .rsp_fill_color_out (rsp_fill_color_out)
   );

   always #6 clock = ~clock;

   function automatic longint clamp_long(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Exact edge height at the column centre, truncated toward zero, then
   // clamped to the visible rows.
   function automatic logic [EDGE_W-1:0] interp_edge(longint b, longint e, longint t,
                                                      longint dx);
      longint num;
      longint quo;
      num = (e - b) * (2 * t + 1) + 2 * b * dx;
      quo = num / (2 * dx);
      return EDGE_W'(clamp_long(quo, Y_MIN, Y_MAX));
   endfunction

   // Predicts the result of one beat and updates the edge store copy.
   function automatic span_result_type predict_column_span(column_beat_type b);
      span_result_type r;
      longint xs;
      longint dx;
      longint x;
      logic [EDGE_W-1:0] y_low;
      logic [EDGE_W-1:0] y_high;
      r = '0;
      xs = longint'($signed(b.start_x));
      dx = longint'($signed(b.end_x)) - xs;
      if (dx == 0) dx = 1;
      x = longint'(b.column);
      if (x < clamp_long(xs, X_MIN, X_MAX) ||
          x >= clamp_long(longint'($signed(b.end_x)), X_MIN, X_MAX)) return r;
      y_low = interp_edge(longint'($signed(b.bottom_start)),
                          longint'($signed(b.bottom_end)), x - xs, dx);
      y_high = interp_edge(longint'($signed(b.top_start)),
                           longint'($signed(b.top_end)), x - xs, dx);
      if (b.func == FUNC_REC_LOW) begin
         edge_mem[b.column] = y_low;
         return r;
      end
      if (b.func == FUNC_REC_HIGH) begin
         edge_mem[b.column] = y_high;
         return r;
      end
      r.column_drawn = 1'b1;
      r.span_low = y_low;
      r.span_high = y_high;
      r.span_color = b.wall_color;
      if (b.func == FUNC_FLOOR) begin
         r.fill_kind = FILL_FLOOR;
         r.fill_from = edge_mem[b.column];
         r.fill_to = y_low;
         r.fill_color_out = b.fill_color;
      end else if (b.func == FUNC_CEIL) begin
         r.fill_kind = FILL_CEIL;
         r.fill_from = y_high;
         r.fill_to = edge_mem[b.column];
         r.fill_color_out = b.fill_color;
      end
      return r;
   endfunction

   function automatic column_beat_type make_beat(int xs, int xe, int bs, int be, int ts,
                                                 int te, int col, logic [FUNC_W-1:0] func,
                                                 int wc, int fc);
      column_beat_type b;
      b.start_x = COORD_W'(xs);
      b.end_x = COORD_W'(xe);
      b.bottom_start = COORD_W'(bs);
      b.bottom_end = COORD_W'(be);
      b.top_start = COORD_W'(ts);
      b.top_end = COORD_W'(te);
      b.column = COL_W'(col);
      b.func = func;
      b.wall_color = COLOR_W'(wc);
      b.fill_color = COLOR_W'(fc);
      return b;
   endfunction

   // Mostly on-screen heights, now and then anywhere in the 16-bit range.
   function automatic int rand_height();
      if ($urandom_range(99) < 10) return int'($signed(COORD_W'($urandom)));
      return int'($urandom_range(380)) - 60;
   endfunction

   // A wall that spans the given column, with random heights and colours.
   // Now and then the column is moved anywhere, in range or not.
   function automatic column_beat_type wall_over(int col, logic [FUNC_W-1:0] func);
      int xs;
      int xe;
      xs = col - int'($urandom_range(90));
      xe = col + 1 + int'($urandom_range(130));
      if ($urandom_range(99) < 12) col = $urandom_range(255);
      return make_beat(xs, xe, rand_height(), rand_height(), rand_height(), rand_height(),
                       col, func, $urandom, $urandom);
   endfunction

   // Pure noise: every field at random over its whole width.
   function automatic column_beat_type noise_beat();
      return make_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, FUNC_W'($urandom), $urandom, $urandom);
   endfunction

   // Queues either a record then fill pair on one column, a single beat,
   // or a noise beat.
   task automatic add_random_group();
      int pick;
      int col;
      pick = $urandom_range(99);
      col = $urandom_range(1, 254);
      if (pick < 15) begin
         column_q.push_back(noise_beat());
         random_added += 1;
      end else if (pick < 60) begin
         column_q.push_back(wall_over(col, $urandom_range(1) ? FUNC_REC_HIGH : FUNC_REC_LOW));
         column_q.push_back(wall_over(col, $urandom_range(1) ? FUNC_CEIL : FUNC_FLOOR));
         random_added += 2;
      end else begin
         column_q.push_back(wall_over(col, FUNC_W'($urandom_range(7))));
         random_added += 1;
      end
   endtask

   task automatic add_directed();
      // A plain wall, its left edge column, and its right edge column, which is excluded.
      column_q.push_back(make_beat(10, 100, 50, 60, 150, 200, 40, FUNC_WALL, 'h123456, 'h654321));
      column_q.push_back(make_beat(10, 100, 50, 60, 150, 200, 10, FUNC_WALL, 'h0000FF, 'h00FF00));
      column_q.push_back(make_beat(10, 100, 50, 60, 150, 200, 100, FUNC_WALL, 'h111111, 'h0));
      // A wall wider than the screen: columns 0 and 255 fall outside the clamped range.
      column_q.push_back(make_beat(-100, 300, 20, 40, 100, 240, 0, FUNC_WALL, 'hABCDEF, 'h0));
      column_q.push_back(make_beat(-100, 300, 20, 40, 100, 240, 1, FUNC_WALL, 'hABCDEF, 'h0));
      column_q.push_back(make_beat(-100, 300, 20, 40, 100, 240, 254, FUNC_WALL, 'hABCDEF, 'h0));
      column_q.push_back(make_beat(-100, 300, 20, 40, 100, 240, 255, FUNC_WALL, 'hABCDEF, 'h0));
      // A wall of zero width, and a wall whose ends are swapped.
      column_q.push_back(make_beat(50, 50, 20, 40, 100, 240, 50, FUNC_WALL, 'h1, 'h2));
      column_q.push_back(make_beat(200, 20, 20, 40, 100, 240, 100, FUNC_WALL, 'h1, 'h2));
      // Coordinate extremes, and edges clamped at both ends of the screen.
      column_q.push_back(make_beat(-32768, 32767, -32768, 32767, 32767, -32768, 128, FUNC_WALL,
                                   'hFFFFFF, 'h0));
      column_q.push_back(make_beat(0, 255, -500, -500, 1000, 900, 77, FUNC_WALL, 'h0, 'hFFFFFF));
      // Record the lower edge, then a floor fill against it.
      column_q.push_back(make_beat(0, 200, 30, 80, 150, 220, 60, FUNC_REC_LOW, 'h5, 'h6));
      column_q.push_back(make_beat(20, 120, 90, 110, 180, 230, 60, FUNC_FLOOR, 'h7, 'h8));
      // Record the upper edge, then a ceiling fill against it.
      column_q.push_back(make_beat(0, 200, 30, 80, 150, 220, 61, FUNC_REC_HIGH, 'h5, 'h6));
      column_q.push_back(make_beat(20, 120, 40, 50, 100, 120, 61, FUNC_CEIL, 'h9, 'hA));
      // Fills against columns that were never recorded.
      column_q.push_back(make_beat(0, 200, 30, 80, 150, 220, 70, FUNC_FLOOR, 'hB, 'hC));
      column_q.push_back(make_beat(0, 200, 30, 80, 150, 220, 71, FUNC_CEIL, 'hD, 'hE));
      // A record on a column outside the wall must leave the store alone.
      column_q.push_back(make_beat(100, 120, 30, 80, 150, 220, 80, FUNC_REC_LOW, 'h0, 'h0));
      column_q.push_back(make_beat(0, 200, 30, 80, 150, 220, 80, FUNC_FLOOR, 'hF, 'h10));
      // Unused mode codes draw the wall only.
      column_q.push_back(make_beat(5, 250, 10, 90, 120, 250, 90, 3'd5, 'h11, 'h12));
      column_q.push_back(make_beat(5, 250, 10, 90, 120, 250, 91, 3'd6, 'h13, 'h14));
      column_q.push_back(make_beat(5, 250, 10, 90, 120, 250, 92, 3'd7, 'h15, 'h16));
      // A floor fill whose stored edge lies above the wall bottom gives an empty span.
      column_q.push_back(make_beat(0, 200, 200, 200, 240, 240, 62, FUNC_REC_LOW, 'h0, 'h0));
      column_q.push_back(make_beat(0, 200, 20, 20, 240, 240, 62, FUNC_FLOOR, 'h17, 'h18));
   endtask

   task automatic wait_drained();
      while (column_q.size() != 0 || req_valid || span_due_q.size() != 0) @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      random_added = 0;
      while (random_added < RANDOM_PER_PHASE) add_random_group();
      wait_drained();
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                  results_seen, what, got, want);
   endtask

   task automatic check_field(string name, longint got, longint want);
      if (got != want) report_mismatch(name, got, want);
   endtask

   // Driver: record the beat accepted at this edge, then hold it or offer the next.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) span_due_q.push_back(predict_column_span(bus_beat));
         if (req_valid && !req_ready) begin
            // The current beat stays on the bus until it is taken.
         end else if (column_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            bus_beat = column_q.pop_front();
            req_start_x <= bus_beat.start_x;
            req_end_x <= bus_beat.end_x;
            req_bottom_start <= bus_beat.bottom_start;
            req_bottom_end <= bus_beat.bottom_end;
            req_top_start <= bus_beat.top_start;
            req_top_end <= bus_beat.top_end;
            req_column <= bus_beat.column;
            req_func <= bus_beat.func;
            req_wall_color <= bus_beat.wall_color;
            req_fill_color <= bus_beat.fill_color;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (span_due_q.size() == 0) begin
            report_mismatch("unpredicted result beat", 0, 0);
         end else begin
            rsp_want = span_due_q.pop_front();
            check_field("column_drawn", rsp_column_drawn, rsp_want.column_drawn);
            check_field("span_low", rsp_span_low, rsp_want.span_low);
            check_field("span_high", rsp_span_high, rsp_want.span_high);
            check_field("span_color", rsp_span_color, rsp_want.span_color);
            check_field("fill_kind", rsp_fill_kind, rsp_want.fill_kind);
            check_field("fill_from", rsp_fill_from, rsp_want.fill_from);
            check_field("fill_to", rsp_fill_to, rsp_want.fill_to);
            check_field("fill_color_out", rsp_fill_color_out, rsp_want.fill_color_out);
         end
         results_seen++;
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: end the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("watchdog: no beat moved in %0d cycles", QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      foreach (edge_mem[i]) edge_mem[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      add_directed();
      run_phase(0, 0);
      run_phase(53, 0);
      run_phase(0, 53);
      run_phase(17, 17);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
